// File: sv/pdss_pkg.sv
// Shared types and constants of the periodic diffusion stencil block.
// No dependencies; imported by pdss_cell_unit, the top level and the testbench.
package pdss_pkg;

    localparam int DATA_W     = 32;
    localparam int GAIN_W     = 16;
    localparam int INDEX_W    = 7;
    localparam int LAP_W      = DATA_W + 3;
    localparam int PROD_W     = LAP_W + GAIN_W + 1;
    localparam int FRAC_W     = 16;
    localparam logic [GAIN_W-1:0] GAIN_RESET = 16'd13107;

    typedef enum logic [1:0] {
        CMD_WRITE = 2'd0,
        CMD_READ  = 2'd1,
        CMD_STEP  = 2'd2,
        CMD_NOP   = 2'd3
    } t_cmd;

    // Three neighboring cells fed to the update unit.
    typedef struct packed {
        logic signed [DATA_W-1:0] left;
        logic signed [DATA_W-1:0] mid;
        logic signed [DATA_W-1:0] right;
    } t_taps;

endpackage

// File: sv/pdss_ram.sv
// Generic simple dual-port RAM with one write port and one registered read port.
// No dependencies.
module pdss_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 128,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_wr_addr,
    input  logic [WIDTH-1:0] i_wr_data,
    input  logic [AW-1:0]    i_rd_addr,
    output logic [WIDTH-1:0] o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

// File: sv/pdss_cell_unit.sv
// Shared cell update unit: Laplacian, gain multiply, rounding and saturation.
// Depends on pdss_pkg. Two register stages; the write-back is combinational.
module pdss_cell_unit
    import pdss_pkg::*;
#(
    parameter int IW = 7
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_valid,
    input  logic [IW-1:0]            i_idx,
    input  t_taps                    i_taps,
    input  logic [GAIN_W-1:0]        i_gain,
    output logic                     o_wb_valid,
    output logic [IW-1:0]            o_wb_idx,
    output logic signed [DATA_W-1:0] o_wb_value,
    output logic                     o_wb_sat
);

    logic                       r_va, r_vb;
    logic [IW-1:0]              r_idx_a, r_idx_b;
    logic signed [DATA_W-1:0]   r_mid_a, r_mid_b;
    logic signed [LAP_W-1:0]    r_lap;
    logic signed [PROD_W-1:0]   r_prod;

    logic signed [LAP_W-1:0]    n_lap;
    logic signed [PROD_W-1:0]   n_prod;
    logic signed [PROD_W-1:0]   w_rnd;
    logic signed [PROD_W-FRAC_W-1:0] w_delta;
    logic signed [DATA_W+4:0]   w_sum;
    logic                       w_ovf;

    assign n_lap = LAP_W'(i_taps.right) - (LAP_W'(i_taps.mid) <<< 1) + LAP_W'(i_taps.left);
    assign n_prod = r_lap * $signed({1'b0, i_gain});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_va <= 1'b0;
            r_vb <= 1'b0;
        end else begin
            r_va <= i_valid;
            r_vb <= r_va;
        end
        r_idx_a <= i_idx;
        r_mid_a <= i_taps.mid;
        r_lap   <= n_lap;
        r_idx_b <= r_idx_a;
        r_mid_b <= r_mid_a;
        r_prod  <= n_prod;
    end

    // Round half up, then add to the old value and clamp to 32 bits.
    assign w_rnd   = r_prod + PROD_W'(32768);
    assign w_delta = w_rnd[PROD_W-1:FRAC_W];
    assign w_sum   = (DATA_W+5)'(r_mid_b) + (DATA_W+5)'(w_delta);
    assign w_ovf   = (w_sum[DATA_W+4:DATA_W-1] != {6{1'b0}})
                  && (w_sum[DATA_W+4:DATA_W-1] != {6{1'b1}});

    always_comb begin
        if (!w_ovf) begin
            o_wb_value = w_sum[DATA_W-1:0];
        end else if (w_sum[DATA_W+4]) begin
            o_wb_value = {1'b1, {(DATA_W-1){1'b0}}};
        end else begin
            o_wb_value = {1'b0, {(DATA_W-1){1'b1}}};
        end
    end

    assign o_wb_valid = r_vb;
    assign o_wb_idx   = r_idx_b;
    assign o_wb_sat   = r_vb && w_ovf;

endmodule

// File: sv/periodic_diffusion_stencil_step.sv
// Top level of the periodic 1D explicit diffusion stencil: sequencer and cell store.
// Depends on pdss_pkg, pdss_ram and pdss_cell_unit.
//
//  Channel   Ports                                         Handshake
//  --------  --------------------------------------------  ----------------------------
//  command   i_command, i_cell_index, i_cell_value          taken when start && !busy
//  result    o_read_value, o_saturated                      o_result_valid, one cycle
//  config    i_gain_wdata                                   written when i_gain_we
//
// A write or an unused command gives its result in the cycle after it is taken, and
// the block is ready again at once. A read waits in S_READ, because the cell store
// has a registered read port. A step fetches the first and last cells in S_PRE0 and
// S_PRE1, then one cell a cycle passes through the shared update unit in S_SWEEP,
// and S_DRAIN waits until its stages have written back the last cell; the single
// read port of the cell store sets that pace. Reset is synchronous and active low;
// the cell store is not cleared and reads of unwritten cells are undefined. The
// receiver cannot stall; each result is shown for exactly one cycle.
module periodic_diffusion_stencil_step
    import pdss_pkg::*;
#(
    parameter int CELLS = 128
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      start,
    output logic                      busy,
    input  logic [1:0]                i_command,
    input  logic [INDEX_W-1:0]        i_cell_index,
    input  logic signed [DATA_W-1:0]  i_cell_value,
    input  logic                      i_gain_we,
    input  logic [GAIN_W-1:0]         i_gain_wdata,
    output logic                      o_result_valid,
    output logic signed [DATA_W-1:0]  o_read_value,
    output logic                      o_saturated
);

    localparam int IW = $clog2(CELLS);
    localparam logic [IW-1:0] LAST = IW'(CELLS - 1);

    typedef enum logic [2:0] {
        S_IDLE,
        S_READ,
        S_PRE0,
        S_PRE1,
        S_SWEEP,
        S_DRAIN
    } t_state;

    t_state                   r_state, n_state;
    logic [IW-1:0]            r_cnt, n_cnt;
    logic signed [DATA_W-1:0] r_first, n_first;
    logic signed [DATA_W-1:0] r_left, n_left;
    logic signed [DATA_W-1:0] r_mid, n_mid;
    logic                     r_sat, n_sat;
    logic                     r_in_range, n_in_range;
    logic                     r_res_valid, n_res_valid;
    logic signed [DATA_W-1:0] r_res_value, n_res_value;
    logic                     r_res_sat, n_res_sat;
    logic [GAIN_W-1:0]        r_gain;

    logic                     w_accept;
    logic [31:0]              w_idx32;
    logic                     w_idx_ok;
    logic [31:0]              w_next2;

    logic [IW-1:0]            w_rd_addr;
    logic [DATA_W-1:0]        w_rd_data;
    logic                     w_we;
    logic [IW-1:0]            w_wr_addr;
    logic [DATA_W-1:0]        w_wr_data;

    logic                     w_feed;
    t_taps                    w_taps;
    logic                     w_wb_valid;
    logic [IW-1:0]            w_wb_idx;
    logic signed [DATA_W-1:0] w_wb_value;
    logic                     w_wb_sat;

    assign busy     = (r_state != S_IDLE);
    assign w_accept = start && !busy;
    assign w_idx32  = 32'(i_cell_index);
    assign w_idx_ok = (w_idx32 < 32'(CELLS));
    assign w_next2  = 32'(r_cnt) + 32'd2;

    // The user must write the gain register only while the block is idle; the block itself does not enforce it.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gain <= GAIN_RESET;
        end else if (i_gain_we) begin
            r_gain <= i_gain_wdata;
        end
    end

    // Read address: the addressed cell for a read, cell 0 when a step starts, the
    // last cell next, then cell 1, then the cell two ahead of the one being fed.
    always_comb begin
        w_rd_addr = '0;
        case (r_state)
            S_IDLE: begin
                if (start && (i_command == CMD_READ)) begin
                    w_rd_addr = w_idx32[IW-1:0];
                end
            end
            S_PRE0:  w_rd_addr = LAST;
            S_PRE1:  w_rd_addr = IW'(1);
            S_SWEEP: begin
                if (w_next2 < 32'(CELLS)) begin
                    w_rd_addr = w_next2[IW-1:0];
                end
            end
            default: w_rd_addr = '0;
        endcase
    end

    // Host writes happen only in idle; the unit writes back only during a step.
    always_comb begin
        if (w_accept && (i_command == CMD_WRITE)) begin
            w_we      = w_idx_ok;
            w_wr_addr = w_idx32[IW-1:0];
            w_wr_data = i_cell_value;
        end else begin
            w_we      = w_wb_valid;
            w_wr_addr = w_wb_idx;
            w_wr_data = w_wb_value;
        end
    end

    // During the sweep the right neighbor comes from the store, except for the last
    // cell, whose right neighbor is the old first cell kept at the start of the step.
    assign w_feed       = (r_state == S_SWEEP);
    assign w_taps.left  = r_left;
    assign w_taps.mid   = r_mid;
    assign w_taps.right = (r_cnt == LAST) ? r_first : w_rd_data;

    always_comb begin
        n_state     = r_state;
        n_cnt       = r_cnt;
        n_first     = r_first;
        n_left      = r_left;
        n_mid       = r_mid;
        n_sat       = r_sat;
        n_in_range  = r_in_range;
        n_res_valid = 1'b0;
        n_res_value = '0;
        n_res_sat   = 1'b0;

        if (w_wb_valid && w_wb_sat) begin
            n_sat = 1'b1;
        end

        case (r_state)
            S_IDLE: begin
                if (start) begin
                    case (i_command)
                        CMD_READ: begin
                            n_in_range = w_idx_ok;
                            n_state    = S_READ;
                        end
                        CMD_STEP: begin
                            n_sat   = 1'b0;
                            n_state = S_PRE0;
                        end
                        default: n_res_valid = 1'b1;
                    endcase
                end
            end
            S_READ: begin
                n_res_valid = 1'b1;
                n_res_value = r_in_range ? w_rd_data : '0;
                n_state     = S_IDLE;
            end
            S_PRE0: begin
                n_first = w_rd_data;
                n_mid   = w_rd_data;
                n_state = S_PRE1;
            end
            S_PRE1: begin
                n_left  = w_rd_data;
                n_cnt   = '0;
                n_state = S_SWEEP;
            end
            S_SWEEP: begin
                n_left = r_mid;
                n_mid  = w_taps.right;
                n_cnt  = r_cnt + IW'(1);
                if (r_cnt == LAST) begin
                    n_state = S_DRAIN;
                end
            end
            S_DRAIN: begin
                if (w_wb_valid && (w_wb_idx == LAST)) begin
                    n_res_valid = 1'b1;
                    n_res_sat   = r_sat || w_wb_sat;
                    n_state     = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_res_valid <= 1'b0;
            r_sat       <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_res_valid <= n_res_valid;
            r_sat       <= n_sat;
        end
        r_cnt       <= n_cnt;
        r_first     <= n_first;
        r_left      <= n_left;
        r_mid       <= n_mid;
        r_in_range  <= n_in_range;
        r_res_value <= n_res_value;
        r_res_sat   <= n_res_sat;
    end

    assign o_result_valid = r_res_valid;
    assign o_read_value   = r_res_value;
    assign o_saturated    = r_res_sat;

    pdss_ram #(
        .WIDTH(DATA_W),
        .DEPTH(CELLS)
    ) u_field_store (
        .i_clk     (i_clk),
        .i_we      (w_we),
        .i_wr_addr (w_wr_addr),
        .i_wr_data (w_wr_data),
        .i_rd_addr (w_rd_addr),
        .o_rd_data (w_rd_data)
    );

    pdss_cell_unit #(
        .IW(IW)
    ) u_cell_unit (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (w_feed),
        .i_idx      (r_cnt),
        .i_taps     (w_taps),
        .i_gain     (r_gain),
        .o_wb_valid (w_wb_valid),
        .o_wb_idx   (w_wb_idx),
        .o_wb_value (w_wb_value),
        .o_wb_sat   (w_wb_sat)
    );

    // A result is only ever shown once the sequencer is back in idle.
    a_result_when_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid |-> !busy)
        else $error("result strobe while busy");

    // Writes and unused commands finish in the cycle after acceptance.
    a_short_cmd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && ((i_command == CMD_WRITE) || (i_command == CMD_NOP)))
        |=> (o_result_valid && !busy))
        else $error("write or unused command did not finish at once");

    // A read keeps the block busy in S_READ and then shows its result.
    a_read_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && (i_command == CMD_READ)) |=> busy ##1 o_result_valid)
        else $error("read result late");

    // The update unit writes back only while a step is in progress.
    a_wb_in_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_wb_valid |-> ((r_state == S_SWEEP) || (r_state == S_DRAIN)))
        else $error("cell write-back outside a step");

    // The sweep counter stays inside the ring.
    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SWEEP) |-> (32'(r_cnt) < 32'(CELLS)))
        else $error("sweep index beyond ring");

endmodule

// File: dv/pdss_result_checker.sv
`timescale 1ns / 1ps
// Result checker for the periodic diffusion stencil: keeps its own cell ring and gain,
// predicts the result of every accepted item and compares it with what the block returns.
// Depends on pdss_pkg for the widths, the command codes and the reset value of the gain.
module pdss_result_checker
    import pdss_pkg::*;
#(
    parameter int CELLS = 128
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_start,
    input  logic                      i_busy,
    input  logic [1:0]                i_command,
    input  logic [INDEX_W-1:0]        i_cell_index,
    input  logic signed [DATA_W-1:0]  i_cell_value,
    input  logic                      i_gain_we,
    input  logic [GAIN_W-1:0]         i_gain_wdata,
    input  logic                      i_result_valid,
    input  logic signed [DATA_W-1:0]  i_read_value,
    input  logic                      i_saturated,
    output int                        o_fail_count,
    output int                        o_pending,
    output int                        o_checked,
    output int                        o_sat_results
);

    typedef struct packed {
        logic signed [DATA_W-1:0] read_value;
        logic                     saturated;
    } t_cell_result;

    localparam longint CELL_MAX = 64'sd2147483647;
    localparam longint CELL_MIN = -64'sd2147483648;

    logic signed [DATA_W-1:0] ring_cells [CELLS];
    logic [GAIN_W-1:0]        gain_q = GAIN_RESET;
    t_cell_result             pending_results [$];

    int fail_count    = 0;
    int pending_count = 0;
    int checked_count = 0;
    int sat_count     = 0;

    assign o_fail_count  = fail_count;
    assign o_pending     = pending_count;
    assign o_checked     = checked_count;
    assign o_sat_results = sat_count;

    initial begin
        foreach (ring_cells[i]) ring_cells[i] = '0;
    end

    // One explicit diffusion step over the whole ring, from a snapshot of the old field.
    // Returns 1 when any cell had to be clamped to the 32-bit range.
    function automatic logic diffuse_ring();
        logic signed [DATA_W-1:0] old_cells [CELLS];
        longint left_v, mid_v, right_v, gain_v, lap, delta, sum;
        logic clamped;
        clamped = 1'b0;
        old_cells = ring_cells;
        gain_v = gain_q;
        for (int i = 0; i < CELLS; i++) begin
            left_v  = old_cells[(i + CELLS - 1) % CELLS];
            mid_v   = old_cells[i];
            right_v = old_cells[(i + 1) % CELLS];
            lap     = right_v - 2 * mid_v + left_v;
            // Round half up, then floor: the arithmetic shift floors negative values.
            delta   = (lap * gain_v + 64'sd32768) >>> FRAC_W;
            sum     = mid_v + delta;
            if (sum > CELL_MAX) begin
                clamped = 1'b1;
                sum = CELL_MAX;
            end else if (sum < CELL_MIN) begin
                clamped = 1'b1;
                sum = CELL_MIN;
            end
            ring_cells[i] = sum[DATA_W-1:0];
        end
        return clamped;
    endfunction

    always @(posedge i_clk) begin
        t_cell_result predicted;
        t_cell_result observed;
        if (!i_rst_n) begin
            gain_q = GAIN_RESET;
            pending_results.delete();
        end else begin
            if (i_gain_we) gain_q = i_gain_wdata;

            // Compare first: an item taken at this edge cannot have its result here.
            if (i_result_valid) begin
                observed.read_value = i_read_value;
                observed.saturated  = i_saturated;
                checked_count++;
                if (observed.saturated === 1'b1) sat_count++;
                if (pending_results.size() == 0) begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display("%0t: unexpected result, read_value %0d (0x%08h) saturated %b",
                                 $realtime, observed.read_value, observed.read_value,
                                 observed.saturated);
                end else begin
                    predicted = pending_results.pop_front();
                    if (observed.read_value !== predicted.read_value ||
                        observed.saturated !== predicted.saturated) begin
                        fail_count++;
                        if (fail_count <= 10)
                            $display("%0t: mismatch, read_value exp %0d got %0d, sat exp %b got %b",
                                     $realtime, predicted.read_value, observed.read_value,
                                     predicted.saturated, observed.saturated);
                    end
                end
            end

            if (i_start && !i_busy) begin
                predicted = '0;
                case (t_cmd'(i_command))
                    CMD_WRITE: if (int'(i_cell_index) < CELLS)
                                   ring_cells[i_cell_index] = i_cell_value;
                    CMD_READ:  if (int'(i_cell_index) < CELLS)
                                   predicted.read_value = ring_cells[i_cell_index];
                    CMD_STEP:  predicted.saturated = diffuse_ring();
                    default:   ;
                endcase
                pending_results.push_back(predicted);
            end
        end
        pending_count = pending_results.size();
    end

endmodule

// File: dv/tb_top.sv
`timescale 1ns / 1ps
// Testbench top for periodic_diffusion_stencil_step: clock, reset, command and gain stimulus.
// Depends on pdss_pkg, the block itself and pdss_result_checker, which does all checking.
module tb_top;
    import pdss_pkg::*;

    localparam int CELLS         = 128;
    localparam int CLK_HALF      = 4;
    // This margin covers a whole step at the end of the run.
    localparam int SETTLE_CYCLES = CELLS + 16;
    localparam logic signed [DATA_W-1:0] VALUE_MAX = 32'sh7fff_ffff;
    localparam logic signed [DATA_W-1:0] VALUE_MIN = 32'sh8000_0000;

    logic                     clk          = 1'b0;
    logic                     rst_n        = 1'b0;
    logic                     start        = 1'b0;
    logic                     busy;
    logic [1:0]               command      = CMD_NOP;
    logic [INDEX_W-1:0]       cell_index   = '0;
    logic signed [DATA_W-1:0] cell_value   = '0;
    logic                     gain_we      = 1'b0;
    logic [GAIN_W-1:0]        gain_wdata   = '0;
    logic                     result_valid;
    logic signed [DATA_W-1:0] read_value;
    logic                     saturated;

    int fail_count;
    int pending;
    int checked;
    int sat_results;

    // Items issued per command code, and how many gain values the run went through.
    int issued [4] = '{default: 0};
    int gain_settings = 1;

    always #(CLK_HALF) clk = ~clk;

    periodic_diffusion_stencil_step #(
        .CELLS(CELLS)
    ) i_dut (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .start          (start),
        .busy           (busy),
        .i_command      (command),
        .i_cell_index   (cell_index),
        .i_cell_value   (cell_value),
        .i_gain_we      (gain_we),
        .i_gain_wdata   (gain_wdata),
        .o_result_valid (result_valid),
        .o_read_value   (read_value),
        .o_saturated    (saturated)
    );

    pdss_result_checker #(
        .CELLS(CELLS)
    ) u_checker (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .i_start        (start),
        .i_busy         (busy),
        .i_command      (command),
        .i_cell_index   (cell_index),
        .i_cell_value   (cell_value),
        .i_gain_we      (gain_we),
        .i_gain_wdata   (gain_wdata),
        .i_result_valid (result_valid),
        .i_read_value   (read_value),
        .i_saturated    (saturated),
        .o_fail_count   (fail_count),
        .o_pending      (pending),
        .o_checked      (checked),
        .o_sat_results  (sat_results)
    );

    // Presents one item at a falling edge and holds it until a rising edge finds the
    // block not busy. Returns at the next falling edge with start still high, so that a
    // following item can be presented in the same time step without a low pulse.
    task automatic issue_item(input t_cmd cmd, input logic [INDEX_W-1:0] idx,
                              input logic signed [DATA_W-1:0] val);
        start      <= 1'b1;
        command    <= cmd;
        cell_index <= idx;
        cell_value <= val;
        do @(posedge clk); while (busy);
        @(negedge clk);
        issued[cmd]++;
    endtask

    // The sender goes quiet for a number of cycles. Called at a falling edge.
    task automatic idle_sender(input int cycles);
        start <= 1'b0;
        repeat (cycles) @(negedge clk);
    endtask

    // Holds the sender off until the checker has seen every outstanding result.
    // Every item produces exactly one result, so nothing can still be in flight after.
    task automatic wait_drained();
        start <= 1'b0;
        @(negedge clk);
        while (pending != 0) @(negedge clk);
    endtask

    // The gain is only changed while the block is idle.
    task automatic write_gain(input logic [GAIN_W-1:0] gain);
        wait_drained();
        repeat (4) @(negedge clk);
        gain_we    <= 1'b1;
        gain_wdata <= gain;
        @(negedge clk);
        gain_we    <= 1'b0;
        @(negedge clk);
        gain_settings++;
    endtask

    // Cell contents: full-range noise, the two extremes, values near zero, and
    // sign-extended mid-range values that keep the field from saturating at once.
    function automatic logic signed [DATA_W-1:0] pick_cell_value();
        logic signed [DATA_W-1:0] v;
        case ($urandom_range(0, 7))
            0, 1:    v = $urandom;
            2:       v = VALUE_MAX;
            3:       v = VALUE_MIN;
            4, 5: begin
                v = $urandom_range(0, 32'h000f_ffff);
                v = v - 32'sh0008_0000;
            end
            default: begin
                v = $urandom;
                v = v >>> 8;
            end
        endcase
        return v;
    endfunction

    // Random traffic. All cells hold a written value by now, so reads and steps are
    // free to touch any cell. Unused fields carry random bits as well.
    task automatic run_random(input int count, input int idle_pct);
        int pick;
        for (int n = 0; n < count; n++) begin
            if ($urandom_range(0, 99) < idle_pct)
                idle_sender($urandom_range(1, 12));
            pick = $urandom_range(0, 99);
            if (pick < 38)
                issue_item(CMD_WRITE, INDEX_W'($urandom), pick_cell_value());
            else if (pick < 70)
                issue_item(CMD_READ, INDEX_W'($urandom), $urandom);
            else if (pick < 92)
                issue_item(CMD_STEP, INDEX_W'($urandom), $urandom);
            else
                issue_item(CMD_NOP, INDEX_W'($urandom), $urandom);
        end
    endtask

    initial begin
        // Synchronous reset, asserted from time zero and never asserted again.
        repeat (8) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Load every cell first: the store is not cleared by reset, and neither a read
        // nor a step may ever see a cell that was never written.
        for (int i = 0; i < CELLS; i++) begin
            if ($urandom_range(0, 99) < 25)
                idle_sender($urandom_range(1, 12));
            issue_item(CMD_WRITE, INDEX_W'(i), pick_cell_value());
        end

        // Directed part at the reset gain: extreme values and the highest and lowest
        // cells, alternating bit patterns, every command, and the unused command code.
        issue_item(CMD_WRITE, 7'd0,   VALUE_MAX);
        issue_item(CMD_WRITE, 7'd127, VALUE_MIN);
        issue_item(CMD_WRITE, 7'd1,   32'sd0);
        issue_item(CMD_WRITE, 7'd64,  32'shffff_ffff);
        issue_item(CMD_WRITE, 7'd63,  32'sh5555_5555);
        issue_item(CMD_WRITE, 7'd65,  32'shaaaa_aaaa);
        issue_item(CMD_READ,  7'd0,   32'sh5555_5555);
        issue_item(CMD_READ,  7'd127, 32'shaaaa_aaaa);
        issue_item(CMD_READ,  7'd64,  32'sd0);
        issue_item(CMD_NOP,   7'd127, 32'shffff_ffff);
        issue_item(CMD_STEP,  7'd0,   32'sd0);
        issue_item(CMD_READ,  7'd0,   32'sd0);
        issue_item(CMD_READ,  7'd127, 32'sd0);
        run_random(120, 30);

        // Largest gain, far past the stable limit: neighbors at opposite extremes now
        // drive the update past the 32-bit range, so the clamp and its flag must show.
        write_gain(16'hffff);
        issue_item(CMD_WRITE, 7'd0,   VALUE_MAX);
        issue_item(CMD_WRITE, 7'd1,   32'sd0);
        issue_item(CMD_WRITE, 7'd127, VALUE_MIN);
        issue_item(CMD_STEP,  7'd0,   32'sd0);
        issue_item(CMD_READ,  7'd0,   32'sd0);
        issue_item(CMD_READ,  7'd1,   32'sd0);
        issue_item(CMD_STEP,  7'd127, 32'shffff_ffff);
        issue_item(CMD_NOP,   7'd0,   32'sd0);
        run_random(120, 30);

        // Zero gain leaves the field as it is; the stable limit and the smallest
        // nonzero gain follow, then random settings inside and outside the stable range.
        write_gain(16'd0);
        run_random(120, 50);
        write_gain(16'd32768);
        run_random(120, 20);
        write_gain(16'd1);
        run_random(100, 30);
        write_gain(GAIN_W'($urandom_range(2, 32767)));
        run_random(120, 40);
        write_gain(GAIN_W'($urandom_range(32769, 65535)));
        run_random(100, 30);

        // Last part: the sender never pauses, so steps and reads go back to back.
        write_gain(GAIN_W'($urandom_range(0, 32768)));
        run_random(100, 0);

        wait_drained();
        repeat (SETTLE_CYCLES) @(negedge clk);

        $display("Sent %0d writes, %0d reads, %0d steps and %0d unused commands under %0d gains.",
                 issued[CMD_WRITE], issued[CMD_READ], issued[CMD_STEP], issued[CMD_NOP],
                 gain_settings);
        $display("Checked %0d results, %0d of them flagged as saturated.", checked, sat_results);
        if (fail_count == 0 && pending == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

    // A correct run needs well under a fifth of this time, even with every item a step.
    initial begin
        #(8_000_000);
        $display("TB_ERROR");
        $finish;
    end

endmodule
